[src/cbp_pkg.sv]
package cbp_pkg;

  localparam int MAX_DIM_DEF = 4096;
  localparam int DIM_W       = 13;
  localparam int POS_W       = 12;
  localparam int BND_W       = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 13;

  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_RED     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_GREEN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_BLUE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_ALPHA   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

  localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
  localparam logic [7:0] LEVEL_9      = 8'd9;
  localparam logic [7:0] LEVEL_19     = 8'd19;
  localparam logic [7:0] LEVEL_29     = 8'd29;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [POS_W-1:0] pixel_col;
    logic [POS_W-1:0] pixel_row;
    logic [7:0]       in_red;
    logic [7:0]       in_green;
    logic [7:0]       in_blue;
    logic [7:0]       in_alpha;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
  } result_t;

  typedef struct packed {
    logic             pattern_mode;
    logic [7:0]       fill_red;
    logic [7:0]       fill_green;
    logic [7:0]       fill_blue;
    logic [7:0]       fill_alpha;
    logic [DIM_W-1:0] frame_width;
    logic [DIM_W-1:0] frame_height;
  } cfg_t;

  // Bar geometry as exclusive upper limits: h, h1 and ty on y, the others on x.
  typedef struct packed {
    logic [DIM_W-1:0]            h;
    logic [DIM_W-1:0]            h1;
    logic [DIM_W-1:0]            ty;
    logic                        lower_en;
    logic [6:0][BND_W-1:0]       col_end;
    logic [3:0][BND_W-1:0]       lw_end;
    logic [BND_W-1:0]            s5_sw;
    logic [BND_W-1:0]            s5_2sw;
  } geom_t;

  typedef struct packed {
    logic s2;
    logic s3;
  } stage_en_t;

  localparam rgb_t UPPER_RGB [7] = '{
    '{8'd192, 8'd192, 8'd192}, '{8'd192, 8'd192, 8'd0}, '{8'd0, 8'd192, 8'd192},
    '{8'd0, 8'd192, 8'd0}, '{8'd192, 8'd0, 8'd192}, '{8'd192, 8'd0, 8'd0},
    '{8'd0, 8'd0, 8'd192}
  };

  localparam rgb_t MIDDLE_RGB [7] = '{
    '{8'd0, 8'd0, 8'd192}, '{8'd19, 8'd19, 8'd19}, '{8'd192, 8'd0, 8'd192},
    '{8'd19, 8'd19, 8'd19}, '{8'd0, 8'd192, 8'd192}, '{8'd19, 8'd19, 8'd19},
    '{8'd192, 8'd192, 8'd192}
  };

  localparam rgb_t LOWER_RGB [4] = '{
    '{8'd0, 8'd33, 8'd76}, '{8'd255, 8'd255, 8'd255}, '{8'd50, 8'd0, 8'd106},
    '{8'd19, 8'd19, 8'd19}
  };

  // Constant divisions by reciprocal multiplication. Each one is exact over the
  // range of values that the geometry and blend paths can present.
  function automatic logic [10:0] div7(input logic [13:0] n);
    logic [29:0] p;
    p = {16'd0, n} * 30'd9363;
    return p[26:16];
  endfunction

  function automatic logic [8:0] div21(input logic [13:0] n);
    logic [27:0] p;
    p = {14'd0, n} * 28'd3121;
    return p[24:16];
  endfunction

  function automatic logic [12:0] div3(input logic [14:0] n);
    logic [29:0] p;
    p = {15'd0, n} * 30'd21846;
    return p[28:16];
  endfunction

  function automatic logic [9:0] div25(input logic [14:0] n);
    logic [31:0] p;
    p = {17'd0, n} * 32'd41944;
    return p[29:20];
  endfunction

  function automatic logic [7:0] div255(input logic [15:0] n);
    logic [32:0] p;
    p = {17'd0, n} * 33'd65794;
    return p[31:24];
  endfunction

endpackage

[src/cbp_stream_if.sv]
interface cbp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[src/color_bar_pattern_generator.sv]
// Color bar / solid fill generator. One pixel transfer is accepted every clock
// cycle unless the sink stalls a full pipeline; each result passes four stage
// registers: an input register, a stage of 8x8 blend products, a stage holding
// the reciprocal divide by 255 next to the bar region compares, and the output
// register. Ready from the sink ripples back through them, so a stalled output
// holds the pipeline in place without losing or repeating a pixel. Register
// writes take effect for any pixel transferred in the cycle after the write;
// the bar geometry is rebuilt from frame_width and frame_height in two
// registered steps that finish before such a pixel reaches the region compares.
module color_bar_pattern_generator #(
  parameter int MAX_DIM = cbp_pkg::MAX_DIM_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0] cfg_data,
  cbp_stream_if.sink                     pixel,
  cbp_stream_if.source                   result
);

  cbp_pkg::cfg_t      cfg;
  cbp_pkg::geom_t     geom;
  cbp_pkg::stage_en_t en;

  logic v1, v2, v3, v4;
  logic rdy1, rdy2, rdy3, rdy4;

  cbp_pkg::pixel_t  px1;
  cbp_pkg::pixel_t  px2;
  cbp_pkg::result_t pass3;
  cbp_pkg::result_t blend_out;
  cbp_pkg::result_t out4;
  cbp_pkg::result_t out_next;
  logic             bar_paint;
  cbp_pkg::rgb_t    bar_rgb;

  cbp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cbp_geom #(
    .MAX_DIM (MAX_DIM)
  ) u_geom (
    .clk  (clk),
    .cfg  (cfg),
    .geom (geom)
  );

  assign rdy4 = !v4 || result.ready;
  assign rdy3 = !v3 || rdy4;
  assign rdy2 = !v2 || rdy3;
  assign rdy1 = !v1 || rdy2;

  assign pixel.ready = rdy1;
  assign en.s2       = rdy2;
  assign en.s3       = rdy3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (rdy1) v1 <= pixel.valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) px1 <= pixel.data;
    if (rdy2) px2 <= px1;
    if (rdy3) begin
      pass3 <= '{px2.in_red, px2.in_green, px2.in_blue, px2.in_alpha};
    end
    if (rdy4) out4 <= out_next;
  end

  cbp_blend u_blend (
    .clk     (clk),
    .en      (en),
    .cfg     (cfg),
    .px      (px1),
    .blended (blend_out)
  );

  cbp_region u_region (
    .clk   (clk),
    .en    (en),
    .geom  (geom),
    .px    (px2),
    .paint (bar_paint),
    .rgb   (bar_rgb)
  );

  always_comb begin
    if (!cfg.pattern_mode) begin
      out_next = blend_out;
    end else if (bar_paint) begin
      out_next = '{bar_rgb.red, bar_rgb.green, bar_rgb.blue, cbp_pkg::ALPHA_OPAQUE};
    end else begin
      out_next = pass3;
    end
  end

  assign result.valid = v4;
  assign result.data  = out4;

  // An accepted transfer always occupies the input stage on the next cycle.
  assert property (@(posedge clk) disable iff (rst)
    (pixel.valid && pixel.ready) |=> v1)
    else $error("accepted pixel did not enter the input stage");

  // A held second stage keeps its pixel for the region compares.
  assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> (v2 && $stable(px2)))
    else $error("stalled pixel changed in the second stage");

  // A painted bar pixel leaves fully opaque.
  assert property (@(posedge clk) disable iff (rst)
    (v3 && rdy4 && cfg.pattern_mode && bar_paint) |=>
      (result.data.out_alpha == cbp_pkg::ALPHA_OPAQUE))
    else $error("painted bar pixel is not opaque");

  // The input side only backs up when every stage is full and the sink stalls.
  assert property (@(posedge clk) disable iff (rst)
    !pixel.ready |-> (v1 && v2 && v3 && v4 && !result.ready))
    else $error("input stalled with room in the pipeline");

endmodule

[src/cbp_cfg.sv]
module cbp_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [cbp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [cbp_pkg::CFG_DATA_W-1:0]     cfg_data,
  output cbp_pkg::cfg_t                      cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pattern_mode <= 1'b0;
      cfg.fill_red     <= 8'd255;
      cfg.fill_green   <= 8'd0;
      cfg.fill_blue    <= 8'd0;
      cfg.fill_alpha   <= 8'd255;
      cfg.frame_width  <= 13'd1920;
      cfg.frame_height <= 13'd1080;
    end else if (cfg_write) begin
      unique case (cfg_index)
        cbp_pkg::REG_PATTERN_MODE: cfg.pattern_mode <= cfg_data[0];
        cbp_pkg::REG_FILL_RED:     cfg.fill_red     <= cfg_data[7:0];
        cbp_pkg::REG_FILL_GREEN:   cfg.fill_green   <= cfg_data[7:0];
        cbp_pkg::REG_FILL_BLUE:    cfg.fill_blue    <= cfg_data[7:0];
        cbp_pkg::REG_FILL_ALPHA:   cfg.fill_alpha   <= cfg_data[7:0];
        cbp_pkg::REG_FRAME_WIDTH:  cfg.frame_width  <= cfg_data;
        cbp_pkg::REG_FRAME_HEIGHT: cfg.frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[src/cbp_geom.sv]
module cbp_geom #(
  parameter int MAX_DIM = cbp_pkg::MAX_DIM_DEF
) (
  input  logic            clk,
  input  cbp_pkg::cfg_t   cfg,
  output cbp_pkg::geom_t  geom
);

  localparam int DIM_MAX_CODE = (1 << cbp_pkg::DIM_W) - 1;
  localparam int DIM_CAP_INT  = (MAX_DIM > DIM_MAX_CODE) ? DIM_MAX_CODE : MAX_DIM;
  localparam logic [cbp_pkg::DIM_W-1:0] DIM_CAP = DIM_CAP_INT[cbp_pkg::DIM_W-1:0];
  localparam int BW = cbp_pkg::BND_W;

  logic [cbp_pkg::DIM_W-1:0] w_clip;
  logic [cbp_pkg::DIM_W-1:0] h_clip;

  // First stage: the divisions, each a constant reciprocal product.
  logic [cbp_pkg::DIM_W-1:0] h_a;
  logic [10:0]               bw_a;
  logic [8:0]                sw_a;
  logic [12:0]               h1_a;
  logic [9:0]                h2_a;

  logic [BW-1:0]             bw_x;
  logic [BW-1:0]             bw5;
  logic [BW-1:0]             lw;
  logic [cbp_pkg::DIM_W-1:0] ty;
  cbp_pkg::geom_t            geom_next;

  assign w_clip = (cfg.frame_width > DIM_CAP) ? DIM_CAP : cfg.frame_width;
  assign h_clip = (cfg.frame_height > DIM_CAP) ? DIM_CAP : cfg.frame_height;

  always_ff @(posedge clk) begin
    h_a  <= h_clip;
    bw_a <= cbp_pkg::div7({1'b0, w_clip} + 14'd6);
    // floor(ceil(w / 7) / 3) folds into one division by 21.
    sw_a <= cbp_pkg::div21({1'b0, w_clip} + 14'd6);
    h1_a <= cbp_pkg::div3({1'b0, h_clip, 1'b0} + 15'd2);
    h2_a <= cbp_pkg::div25({1'b0, h_clip, 1'b0} + 15'd24);
  end

  always_comb begin
    bw_x = {3'b000, bw_a};
    bw5  = (bw_x << 2) + bw_x;
    lw   = bw5 >> 2;
    ty   = h1_a + {3'b000, h2_a};
    geom_next.h        = h_a;
    geom_next.h1       = h1_a;
    geom_next.ty       = ty;
    geom_next.lower_en = ty < h_a;
    for (int i = 0; i < 7; i++) begin
      geom_next.col_end[i] = bw_x * BW'(i + 1);
    end
    for (int k = 0; k < 4; k++) begin
      geom_next.lw_end[k] = lw * BW'(k + 1);
    end
    geom_next.s5_sw  = bw5 + {5'd0, sw_a};
    geom_next.s5_2sw = bw5 + {4'd0, sw_a, 1'b0};
  end

  always_ff @(posedge clk) begin
    geom <= geom_next;
  end

endmodule

[src/cbp_blend.sv]
module cbp_blend (
  input  logic               clk,
  input  cbp_pkg::stage_en_t en,
  input  cbp_pkg::cfg_t      cfg,
  input  cbp_pkg::pixel_t    px,
  output cbp_pkg::result_t   blended
);

  logic [7:0]  inv_a;
  logic [15:0] src_prod [3];
  logic [15:0] dst_prod [3];
  logic [15:0] alpha_prod;
  logic [7:0]  fa2;
  logic [15:0] sum [3];

  assign inv_a = 8'd255 - cfg.fill_alpha;

  always_ff @(posedge clk) begin
    if (en.s2) begin
      src_prod[0] <= {8'd0, cfg.fill_red}   * {8'd0, cfg.fill_alpha};
      src_prod[1] <= {8'd0, cfg.fill_green} * {8'd0, cfg.fill_alpha};
      src_prod[2] <= {8'd0, cfg.fill_blue}  * {8'd0, cfg.fill_alpha};
      dst_prod[0] <= {8'd0, px.in_red}   * {8'd0, inv_a};
      dst_prod[1] <= {8'd0, px.in_green} * {8'd0, inv_a};
      dst_prod[2] <= {8'd0, px.in_blue}  * {8'd0, inv_a};
      alpha_prod  <= {8'd0, px.in_alpha} * {8'd0, inv_a};
      fa2         <= cfg.fill_alpha;
    end
  end

  // The two weighted terms never exceed 255 * 255 together, so 16 bits hold the sum.
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum[c] = src_prod[c] + dst_prod[c];
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      blended.out_red   <= cbp_pkg::div255(sum[0]);
      blended.out_green <= cbp_pkg::div255(sum[1]);
      blended.out_blue  <= cbp_pkg::div255(sum[2]);
      blended.out_alpha <= fa2 + cbp_pkg::div255(alpha_prod);
    end
  end

endmodule

[src/cbp_region.sv]
module cbp_region (
  input  logic               clk,
  input  cbp_pkg::stage_en_t en,
  input  cbp_pkg::geom_t     geom,
  input  cbp_pkg::pixel_t    px,
  output logic               paint,
  output cbp_pkg::rgb_t      rgb
);

  logic [cbp_pkg::BND_W-1:0] x;
  logic [cbp_pkg::BND_W-1:0] y;
  logic [6:0]                col_lt;
  logic [3:0]                lw_lt;
  logic [2:0]                col;
  logic [1:0]                blk;
  logic [7:0]                level;
  logic                      paint_next;
  cbp_pkg::rgb_t             rgb_next;

  always_comb begin
    x = {2'b00, px.pixel_col};
    y = {2'b00, px.pixel_row};
    for (int i = 0; i < 7; i++) begin
      col_lt[i] = x < geom.col_end[i];
    end
    for (int k = 0; k < 4; k++) begin
      lw_lt[k] = x < geom.lw_end[k];
    end
    // The limits rise monotonically, so the lowest one above x names the column.
    col = 3'd0;
    for (int i = 6; i >= 0; i--) begin
      if (col_lt[i]) col = 3'(i);
    end
    blk = 2'd0;
    for (int k = 3; k >= 0; k--) begin
      if (lw_lt[k]) blk = 2'(k);
    end
    if (x < geom.s5_sw) begin
      level = cbp_pkg::LEVEL_9;
    end else if (x < geom.s5_2sw) begin
      level = cbp_pkg::LEVEL_19;
    end else begin
      level = cbp_pkg::LEVEL_29;
    end

    paint_next = 1'b0;
    rgb_next   = '0;
    if (y < {1'b0, geom.ty}) begin
      if (col_lt[6]) begin
        paint_next = 1'b1;
        rgb_next   = (y < {1'b0, geom.h1}) ? cbp_pkg::UPPER_RGB[col]
                                           : cbp_pkg::MIDDLE_RGB[col];
      end
    end else if (geom.lower_en && (y < {1'b0, geom.h})) begin
      if (lw_lt[3]) begin
        paint_next = 1'b1;
        rgb_next   = cbp_pkg::LOWER_RGB[blk];
      end else if (!col_lt[4] && col_lt[5]) begin
        // The pluge strips sit in the sixth column.
        paint_next = 1'b1;
        rgb_next   = '{level, level, level};
      end else if (!col_lt[5] && col_lt[6]) begin
        paint_next = 1'b1;
        rgb_next   = '{cbp_pkg::LEVEL_19, cbp_pkg::LEVEL_19, cbp_pkg::LEVEL_19};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      paint <= paint_next;
      rgb   <= rgb_next;
    end
  end

endmodule
